[design/link_reconnect_backoff_supervisor_macros.svh]
// assertion macros used by lrbs_core of the link reconnect supervisor
// expects signals clk and rst_n in the including module
`ifndef LINK_RECONNECT_BACKOFF_SUPERVISOR_MACROS_SVH
`define LINK_RECONNECT_BACKOFF_SUPERVISOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define LRBS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrbs assertion failed");

// next-cycle implication, checked outside reset
`define LRBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrbs assertion failed");

`endif

[design/lrbs_pkg.sv]
// types, constants and helpers for the link reconnect supervisor
// no dependencies
package lrbs_pkg;

  localparam int unsigned BACKOFF_CAP_MS_DEF = 60000;

  localparam int unsigned NOW_W  = 32;
  localparam int unsigned ATT_W  = 16;
  localparam int unsigned BO_W   = 16;
  localparam int unsigned BASE_W = 15;
  localparam int unsigned JIT_W  = 17;

  localparam logic [BASE_W-1:0] BASE_MIN   = 15'd100;
  localparam logic [BASE_W-1:0] BASE_MAX   = 15'd30000;
  localparam logic [BASE_W-1:0] BASE_RESET = 15'd1000;
  localparam logic [3:0]        MAX_DOUBLINGS = 4'd8;

  // reported link status codes
  localparam logic [1:0] LS_DISC = 2'd0;
  localparam logic [1:0] LS_CONN = 2'd1;
  localparam logic [1:0] LS_DEGR = 2'd2;

  typedef enum logic [2:0] {
    LM_DISC = 3'b001,
    LM_CONN = 3'b010,
    LM_DEGR = 3'b100
  } link_mode_t;

  typedef struct packed {
    logic             mode;
    logic [NOW_W-1:0] now_ms;
    logic             link_up;
    logic             probe_ok;
    logic             send_ok;
    logic             link_up_after_send;
    logic [JIT_W-1:0] jitter_q16;
  } req_t;

  typedef struct packed {
    logic [1:0]       link_state;
    logic             probe_started;
    logic             frame_delivered;
    logic [ATT_W-1:0] attempts;
    logic [BO_W-1:0]  backoff_out_ms;
    logic [NOW_W-1:0] retry_at_ms;
    logic             retry_armed;
  } rsp_t;

  function automatic logic [1:0] link_code(link_mode_t m);
    logic [1:0] c;
    unique case (m)
      LM_DISC: c = LS_DISC;
      LM_CONN: c = LS_CONN;
      LM_DEGR: c = LS_DEGR;
      default: c = LS_DISC;
    endcase
    return c;
  endfunction

endpackage

[design/lrbs_backoff.sv]
// backoff computation: doubled base, clamp, jitter scale, round, clamp
// depends on lrbs_pkg
module lrbs_backoff #(
  parameter int unsigned BACKOFF_CAP_MS = lrbs_pkg::BACKOFF_CAP_MS_DEF
) (
  input  logic [lrbs_pkg::BASE_W-1:0] base_ms,
  input  logic [lrbs_pkg::ATT_W-1:0]  attempts,
  input  logic [lrbs_pkg::JIT_W-1:0]  jitter_q16,
  output logic [lrbs_pkg::BO_W-1:0]   backoff_ms
);
  import lrbs_pkg::*;

  localparam int unsigned SH_W = BASE_W + 8;
  localparam logic [SH_W-1:0] CAP_SH  = SH_W'(BACKOFF_CAP_MS);
  localparam logic [BO_W-1:0] CAP_BO  = BO_W'(BACKOFF_CAP_MS);
  localparam logic [BO_W+1:0] CAP_SC  = (BO_W+2)'(BACKOFF_CAP_MS);

  logic [3:0]              shamt;
  logic [SH_W-1:0]         shifted;
  logic [BO_W-1:0]         clamp1;
  logic [BO_W-1:0]         base_w;
  logic [BO_W+JIT_W-1:0]   prod;
  logic [BO_W+JIT_W:0]     rounded;
  logic [BO_W+1:0]         scaled;

  assign base_w = {1'b0, base_ms};

  always_comb begin
    if (attempts == '0) begin
      shamt = 4'd0;
    end else if (attempts > ATT_W'(MAX_DOUBLINGS)) begin
      shamt = MAX_DOUBLINGS;
    end else begin
      shamt = attempts[3:0] - 4'd1;
    end
  end

  assign shifted = {8'b0, base_ms} << shamt;

  always_comb begin
    clamp1 = (shifted > CAP_SH) ? CAP_BO : shifted[BO_W-1:0];
    if (clamp1 < base_w) begin
      clamp1 = base_w;
    end
  end

  // q1.16 scale with round half up
  assign prod    = clamp1 * jitter_q16;
  assign rounded = {1'b0, prod} + (BO_W+JIT_W+1)'(32768);
  assign scaled  = rounded[BO_W+JIT_W:16];

  always_comb begin
    backoff_ms = (scaled > CAP_SC) ? CAP_BO : scaled[BO_W-1:0];
    if (backoff_ms < base_w) begin
      backoff_ms = base_w;
    end
  end

endmodule

[design/lrbs_core.sv]
// supervisor state, base register and per-request next-state logic
// depends on lrbs_pkg, lrbs_backoff and the assertion macro header
`include "link_reconnect_backoff_supervisor_macros.svh"
module lrbs_core #(
  parameter int unsigned BACKOFF_CAP_MS = lrbs_pkg::BACKOFF_CAP_MS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lrbs_pkg::BASE_W-1:0] cfg_wr_data,
  input  logic                        step,
  input  lrbs_pkg::req_t              req,
  output lrbs_pkg::rsp_t              rsp
);
  import lrbs_pkg::*;

  logic [BASE_W-1:0] base_r, base_nxt;
  link_mode_t        mode_r, mode_nxt;
  logic [ATT_W-1:0]  att_r, att_nxt;
  logic [BO_W-1:0]   bo_r, bo_nxt;
  logic [NOW_W-1:0]  dl_r, dl_nxt;
  logic              dv_r, dv_nxt;

  logic [NOW_W-1:0] diff;
  logic             due;
  logic [ATT_W-1:0] att_inc;
  logic [BO_W-1:0]  bo_new;
  logic             probed;
  logic             delivered;

  // base register, clamped on write
  always_comb begin
    base_nxt = base_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data < BASE_MIN) begin
        base_nxt = BASE_MIN;
      end else if (cfg_wr_data > BASE_MAX) begin
        base_nxt = BASE_MAX;
      end else begin
        base_nxt = cfg_wr_data;
      end
    end
  end

  // wrap-aware deadline check
  assign diff    = req.now_ms - dl_r;
  assign due     = !dv_r || !diff[NOW_W-1];
  assign att_inc = (att_r == '1) ? att_r : att_r + ATT_W'(1);

  lrbs_backoff #(
    .BACKOFF_CAP_MS(BACKOFF_CAP_MS)
  ) u_backoff (
    .base_ms   (base_r),
    .attempts  (att_inc),
    .jitter_q16(req.jitter_q16),
    .backoff_ms(bo_new)
  );

  always_comb begin
    mode_nxt  = mode_r;
    att_nxt   = att_r;
    bo_nxt    = bo_r;
    dl_nxt    = dl_r;
    dv_nxt    = dv_r;
    probed    = 1'b0;
    delivered = 1'b0;
    if (req.mode) begin
      mode_nxt = LM_DISC;
      att_nxt  = '0;
      bo_nxt   = '0;
      dl_nxt   = '0;
      dv_nxt   = 1'b0;
    end else if (!req.link_up) begin
      if (due) begin
        probed = 1'b1;
        if (req.probe_ok) begin
          mode_nxt = LM_CONN;
          att_nxt  = '0;
          bo_nxt   = '0;
          dl_nxt   = '0;
          dv_nxt   = 1'b0;
        end else begin
          mode_nxt = LM_DISC;
          att_nxt  = att_inc;
          bo_nxt   = bo_new;
          dl_nxt   = req.now_ms + NOW_W'(bo_new);
          dv_nxt   = 1'b1;
        end
      end
    end else if (req.send_ok) begin
      delivered = 1'b1;
      mode_nxt  = LM_CONN;
      att_nxt   = '0;
      bo_nxt    = '0;
      dl_nxt    = '0;
      dv_nxt    = 1'b0;
    end else begin
      mode_nxt = LM_DEGR;
      if (!req.link_up_after_send && due) begin
        att_nxt = att_inc;
        bo_nxt  = bo_new;
        dl_nxt  = req.now_ms + NOW_W'(bo_new);
        dv_nxt  = 1'b1;
      end
    end
  end

  always_comb begin
    rsp.link_state      = link_code(mode_nxt);
    rsp.probe_started   = probed;
    rsp.frame_delivered = delivered;
    rsp.attempts        = att_nxt;
    rsp.backoff_out_ms  = bo_nxt;
    rsp.retry_at_ms     = dl_nxt;
    rsp.retry_armed     = dv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      mode_r <= LM_DISC;
      att_r  <= '0;
      bo_r   <= '0;
      dl_r   <= '0;
      dv_r   <= 1'b0;
    end else begin
      base_r <= base_nxt;
      if (step) begin
        mode_r <= mode_nxt;
        att_r  <= att_nxt;
        bo_r   <= bo_nxt;
        dl_r   <= dl_nxt;
        dv_r   <= dv_nxt;
      end
    end
  end

  `LRBS_ASSERT_IMPL(a_armed_iff_attempts, 1'b1, (att_r != '0) == dv_r)
  `LRBS_ASSERT_IMPL(a_disarmed_zero_deadline, !dv_r, dl_r == '0 && bo_r == '0)
  `LRBS_ASSERT_IMPL(a_connected_not_armed, mode_r == LM_CONN, !dv_r)
  `LRBS_ASSERT_NEXT(a_reset_event_clears, step && req.mode,
                    mode_r == LM_DISC && att_r == '0 && !dv_r)

endmodule

[design/link_reconnect_backoff_supervisor.sv]
// top level of the link reconnect supervisor: request register, core, result register
// depends on lrbs_pkg and lrbs_core
//
//   channel   direction  handshake              payload
//   in_*      input      in_valid / in_ready    mode, now, link status, outcomes, jitter
//   out_*     output     out_valid / out_ready  link state, flags, attempts, backoff, deadline
//   cfg_*     input      cfg_wr_en              base delay (15 bits), no read-back
//
// one request per cycle sustained while out_ready holds; each request waits in the request
// register until the result register is free, and its result is then captured there
// rst_n is synchronous, active low; clears supervisor state and sets base to 1000 ms
// when the result register is held, the request register still takes one request;
// in_ready then drops until out_ready frees the result register
module link_reconnect_backoff_supervisor #(
  parameter int unsigned BACKOFF_CAP_MS = lrbs_pkg::BACKOFF_CAP_MS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [lrbs_pkg::NOW_W-1:0]   in_now_ms,
  input  logic                         in_link_up,
  input  logic                         in_probe_ok,
  input  logic                         in_send_ok,
  input  logic                         in_link_up_after_send,
  input  logic [lrbs_pkg::JIT_W-1:0]   in_jitter_q16,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_link_state,
  output logic                         out_probe_started,
  output logic                         out_frame_delivered,
  output logic [lrbs_pkg::ATT_W-1:0]   out_attempts,
  output logic [lrbs_pkg::BO_W-1:0]    out_backoff_out_ms,
  output logic [lrbs_pkg::NOW_W-1:0]   out_retry_at_ms,
  output logic                         out_retry_armed,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [lrbs_pkg::BASE_W-1:0]  cfg_wr_data
);
  import lrbs_pkg::*;

  // request register stage
  logic s1_valid_r, s1_valid_nxt;
  req_t s1_req_r;
  req_t in_req;

  // result register stage
  logic out_valid_r, out_valid_nxt;
  rsp_t out_rsp_r;
  rsp_t core_rsp;

  logic in_fire;
  logic adv;   // request register moves into the result register

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    in_req.mode               = in_mode;
    in_req.now_ms             = in_now_ms;
    in_req.link_up            = in_link_up;
    in_req.probe_ok           = in_probe_ok;
    in_req.send_ok            = in_send_ok;
    in_req.link_up_after_send = in_link_up_after_send;
    in_req.jitter_q16         = in_jitter_q16;
  end

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state update happens on the cycle the request leaves the request register
  lrbs_core #(
    .BACKOFF_CAP_MS(BACKOFF_CAP_MS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .step       (adv),
    .req        (s1_req_r),
    .rsp        (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_req;
    end
    if (adv) begin
      out_rsp_r <= core_rsp;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_link_state      = out_rsp_r.link_state;
  assign out_probe_started   = out_rsp_r.probe_started;
  assign out_frame_delivered = out_rsp_r.frame_delivered;
  assign out_attempts        = out_rsp_r.attempts;
  assign out_backoff_out_ms  = out_rsp_r.backoff_out_ms;
  assign out_retry_at_ms     = out_rsp_r.retry_at_ms;
  assign out_retry_armed     = out_rsp_r.retry_armed;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for link_reconnect_backoff_supervisor: directed table, random passes
// and base delay sweeps, scored against typed hand values or a predictor of supervisor state
// depends on lrbs_pkg and the link_reconnect_backoff_supervisor rtl
module tb;
  import lrbs_pkg::*;

  localparam int unsigned CAP_MS      = BACKOFF_CAP_MS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PRINT_LIMIT = 40;

  // one row of the directed table: request, and optionally a hand-written expected status
  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_mode;
  logic [NOW_W-1:0]    in_now_ms;
  logic                in_link_up;
  logic                in_probe_ok;
  logic                in_send_ok;
  logic                in_link_up_after_send;
  logic [JIT_W-1:0]    in_jitter_q16;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          out_link_state;
  logic                out_probe_started;
  logic                out_frame_delivered;
  logic [ATT_W-1:0]    out_attempts;
  logic [BO_W-1:0]     out_backoff_out_ms;
  logic [NOW_W-1:0]    out_retry_at_ms;
  logic                out_retry_armed;
  logic                cfg_wr_en;
  logic [BASE_W-1:0]   cfg_wr_data;

  link_reconnect_backoff_supervisor DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_mode               (in_mode),
    .in_now_ms             (in_now_ms),
    .in_link_up            (in_link_up),
    .in_probe_ok           (in_probe_ok),
    .in_send_ok            (in_send_ok),
    .in_link_up_after_send (in_link_up_after_send),
    .in_jitter_q16         (in_jitter_q16),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_link_state        (out_link_state),
    .out_probe_started     (out_probe_started),
    .out_frame_delivered   (out_frame_delivered),
    .out_attempts          (out_attempts),
    .out_backoff_out_ms    (out_backoff_out_ms),
    .out_retry_at_ms       (out_retry_at_ms),
    .out_retry_armed       (out_retry_armed),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data)
  );

  // supervisor state as the testbench sees it
  logic [1:0]        sv_link;
  logic [ATT_W-1:0]  sv_attempts;
  logic [BO_W-1:0]   sv_backoff;
  logic [NOW_W-1:0]  sv_deadline;
  logic              sv_armed;
  logic [BASE_W-1:0] sv_base;

  // status words still owed by the block, oldest first
  rsp_t expected_status[$];

  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned results_seen;
  logic [NOW_W-1:0] last_now;
  bit gaps_on;
  bit stalls_on;
  bit hold_off_req;

  initial begin : clock_gen
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog, in case a handshake never completes
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // bound a backoff to [base, cap]; the base wins if it ever sits above the cap
  function automatic logic [BO_W-1:0] clamp_backoff(longint unsigned v);
    if (v > CAP_MS) v = CAP_MS;
    if (v < sv_base) v = sv_base;
    return BO_W'(v);
  endfunction

  // base doubled once per prior failure, at most 8 times, then scaled by the jitter factor
  function automatic logic [BO_W-1:0] next_backoff(logic [JIT_W-1:0] jit);
    longint unsigned b;
    longint unsigned scaled;
    int unsigned shift;
    b = sv_base;
    shift = (sv_attempts == '0) ? 0 : sv_attempts - 1;
    if (shift > MAX_DOUBLINGS) shift = MAX_DOUBLINGS;
    scaled = clamp_backoff(b << shift);
    // q16 multiply, round half up
    scaled = (scaled * jit + 64'd32768) >> 16;
    return clamp_backoff(scaled);
  endfunction

  // wrap-aware: due when no deadline is armed, or once now has reached it in signed 32-bit terms
  function automatic bit retry_due(logic [NOW_W-1:0] now);
    logic [NOW_W-1:0] d;
    d = now - sv_deadline;
    return !sv_armed || !d[NOW_W-1];
  endfunction

  function automatic void clear_retry();
    sv_attempts = '0;
    sv_backoff  = '0;
    sv_deadline = '0;
    sv_armed    = 1'b0;
  endfunction

  function automatic void arm_retry(logic [NOW_W-1:0] now, logic [JIT_W-1:0] jit);
    if (sv_attempts != '1) sv_attempts++;
    sv_backoff  = next_backoff(jit);
    sv_deadline = now + sv_backoff;
    sv_armed    = 1'b1;
  endfunction

  // advance the predicted state by one accepted request and return its status word
  function automatic rsp_t predict_status(req_t r);
    rsp_t s;
    logic probed;
    logic sent;
    probed = 1'b0;
    sent   = 1'b0;
    if (r.mode) begin
      // reset event: everything else in the request is ignored
      sv_link = LS_DISC;
      clear_retry();
    end else if (!r.link_up) begin
      // link down: probe only when no deadline or the deadline has come
      if (retry_due(r.now_ms)) begin
        probed      = 1'b1;
        sv_deadline = '0;
        sv_armed    = 1'b0;
        if (r.probe_ok) begin
          sv_link = LS_CONN;
          clear_retry();
        end else begin
          arm_retry(r.now_ms, r.jitter_q16);
          sv_link = LS_DISC;
        end
      end
    end else if (r.send_ok) begin
      sent    = 1'b1;
      sv_link = LS_CONN;
      clear_retry();
    end else begin
      // send failed: degraded, and a retry if the link also dropped and the retry is due
      sv_link = LS_DEGR;
      if (!r.link_up_after_send && retry_due(r.now_ms)) arm_retry(r.now_ms, r.jitter_q16);
    end
    s.link_state      = sv_link;
    s.probe_started   = probed;
    s.frame_delivered = sent;
    s.attempts        = sv_attempts;
    s.backoff_out_ms  = sv_backoff;
    s.retry_at_ms     = sv_deadline;
    s.retry_armed     = sv_armed;
    return s;
  endfunction

  // append to the list of owed status words
  function automatic void owe_status(rsp_t s);
    expected_status.insert(expected_status.size(), s);
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic req_t mk_req(logic mode, logic [NOW_W-1:0] now, logic up, logic pok,
                                  logic sok, logic upa, logic [JIT_W-1:0] jit);
    req_t r;
    r.mode               = mode;
    r.now_ms             = now;
    r.link_up            = up;
    r.probe_ok           = pok;
    r.send_ok            = sok;
    r.link_up_after_send = upa;
    r.jitter_q16         = jit;
    return r;
  endfunction

  function automatic rsp_t mk_status(logic [1:0] ls, logic ps, logic fd, logic [ATT_W-1:0] att,
                                     logic [BO_W-1:0] bo, logic [NOW_W-1:0] rat, logic arm);
    rsp_t s;
    s.link_state      = ls;
    s.probe_started   = ps;
    s.frame_delivered = fd;
    s.attempts        = att;
    s.backoff_out_ms  = bo;
    s.retry_at_ms     = rat;
    s.retry_armed     = arm;
    return s;
  endfunction

  // random pass, biased toward the current deadline so due and not-due both show up
  function automatic req_t rand_pass();
    req_t r;
    int unsigned pick;
    r.mode               = ($urandom_range(0, 99) < 4);
    r.link_up            = 1'($urandom_range(0, 1));
    r.probe_ok           = ($urandom_range(0, 99) < 30);
    r.send_ok            = ($urandom_range(0, 99) < 40);
    r.link_up_after_send = 1'($urandom_range(0, 1));
    // mostly the nominal 0.88 to 1.14 window, sometimes any 17-bit value
    if ($urandom_range(0, 9) == 0) r.jitter_q16 = JIT_W'($urandom_range(0, 131071));
    else r.jitter_q16 = JIT_W'($urandom_range(57672, 74711));
    pick = $urandom_range(0, 9);
    if (pick == 0) r.now_ms = $urandom();
    else if (sv_armed && pick < 5) r.now_ms = sv_deadline + $urandom_range(0, 2) - 1;
    else r.now_ms = last_now + $urandom_range(0, 2 * sv_backoff + 50);
    last_now = r.now_ms;
    return r;
  endfunction

  // offer one request, hold it until accepted, then log what the block owes for it
  task automatic send_request(req_t r, bit typed, rsp_t want);
    rsp_t p;
    int unsigned gap;
    int unsigned roll;
    if (gaps_on) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_mode               = r.mode;
    in_now_ms             = r.now_ms;
    in_link_up            = r.link_up;
    in_probe_ok           = r.probe_ok;
    in_send_ok            = r.send_ok;
    in_link_up_after_send = r.link_up_after_send;
    in_jitter_q16         = r.jitter_q16;
    in_valid              = 1'b1;
    do @(posedge clk); while (!in_ready);
    p = predict_status(r);
    // typed rows keep the predictor in step but are scored against the hand value
    owe_status(typed ? want : p);
    @(negedge clk);
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) send_request(rand_pass(), 1'b0, '0);
    in_valid = 1'b0;
  endtask

  // base delay is only written with nothing in flight
  task automatic write_base(logic [BASE_W-1:0] v);
    in_valid = 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_data = v;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    if (v < BASE_MIN) sv_base = BASE_MIN;
    else if (v > BASE_MAX) sv_base = BASE_MAX;
    else sv_base = v;
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    err_count++;
    if (err_count <= PRINT_LIMIT)
      $display("tb: mismatch %s got %0d expected %0d at status %0d", what, got, want,
               results_seen);
  endtask

  // ---------------------------------------------------------------- result side

  // receiver: random stalls, and one long hold-off on request so the block backs up
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else if (stall_left == 0 && stalls_on && $urandom_range(0, 99) < 20) begin
        if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(8, 30);
        else stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // score every accepted status word against the oldest expectation
  always @(posedge clk) begin : score_status
    rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected status, count", results_seen, 0);
      end else begin
        want = expected_status.pop_front();
        if (out_link_state != want.link_state)
          report_mismatch("link_state", out_link_state, want.link_state);
        if (out_probe_started != want.probe_started)
          report_mismatch("probe_started", out_probe_started, want.probe_started);
        if (out_frame_delivered != want.frame_delivered)
          report_mismatch("frame_delivered", out_frame_delivered, want.frame_delivered);
        if (out_attempts != want.attempts)
          report_mismatch("attempts", out_attempts, want.attempts);
        if (out_backoff_out_ms != want.backoff_out_ms)
          report_mismatch("backoff_out_ms", out_backoff_out_ms, want.backoff_out_ms);
        if (out_retry_at_ms != want.retry_at_ms)
          report_mismatch("retry_at_ms", out_retry_at_ms, want.retry_at_ms);
        if (out_retry_armed != want.retry_armed)
          report_mismatch("retry_armed", out_retry_armed, want.retry_armed);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin : stimulus
    dir_row_t steps[$];
    dir_row_t row;
    int unsigned i;

    rst_n                 = 1'b0;
    in_valid              = 1'b0;
    in_mode               = 1'b0;
    in_now_ms             = '0;
    in_link_up            = 1'b0;
    in_probe_ok           = 1'b0;
    in_send_ok            = 1'b0;
    in_link_up_after_send = 1'b0;
    in_jitter_q16         = '0;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    gaps_on               = 1'b1;
    stalls_on             = 1'b1;
    hold_off_req          = 1'b0;
    err_count             = 0;
    cycle_count           = 0;
    results_seen          = 0;
    last_now              = '0;

    // predictor starts from the reset state, base at its reset value
    sv_link = LS_DISC;
    sv_base = BASE_RESET;
    clear_retry();

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed table, base 1000 ms; rows with typed clear are scored by the predictor
    // first probe fails, unit jitter: one base of backoff
    row = '{mk_req(0, 32'd0, 0, 0, 0, 0, 17'd65536), 1,
            mk_status(LS_DISC, 1, 0, 16'd1, 16'd1000, 32'd1000, 1)};
    steps = {steps, row};
    // one ms short of the deadline: nothing happens even though a probe would pass
    row = '{mk_req(0, 32'd999, 0, 1, 1, 1, 17'd65536), 1,
            mk_status(LS_DISC, 0, 0, 16'd1, 16'd1000, 32'd1000, 1)};
    steps = {steps, row};
    // deadline reached exactly, second failure doubles the backoff
    row = '{mk_req(0, 32'd1000, 0, 0, 0, 0, 17'd65536), 1,
            mk_status(LS_DISC, 1, 0, 16'd2, 16'd2000, 32'd3000, 1)};
    steps = {steps, row};
    // reset event with every other field at its top value
    row = '{mk_req(1, 32'hFFFF_FFFF, 1, 1, 1, 1, 17'h1FFFF), 1,
            mk_status(LS_DISC, 0, 0, 16'd0, 16'd0, 32'd0, 0)};
    steps = {steps, row};
    // link up, frame goes out
    row = '{mk_req(0, 32'd5, 1, 0, 1, 0, 17'd57672), 1,
            mk_status(LS_CONN, 0, 1, 16'd0, 16'd0, 32'd0, 0)};
    steps = {steps, row};
    // send fails but the link holds: degraded, no retry
    row = '{mk_req(0, 32'd6, 1, 0, 0, 1, 17'd74711), 1,
            mk_status(LS_DEGR, 0, 0, 16'd0, 16'd0, 32'd0, 0)};
    steps = {steps, row};
    // send fails and the link drops at the top of time; jitter just under 2.0, deadline wraps
    row = '{mk_req(0, 32'hFFFF_FFFF, 1, 0, 0, 0, 17'h1FFFF), 1,
            mk_status(LS_DEGR, 0, 0, 16'd1, 16'd2000, 32'd1999, 1)};
    steps = {steps, row};
    // link down before the wrapped deadline: state, degraded mode too, left alone
    row = '{mk_req(0, 32'd1998, 0, 0, 0, 0, 17'd65536), 1,
            mk_status(LS_DEGR, 0, 0, 16'd1, 16'd2000, 32'd1999, 1)};
    steps = {steps, row};
    // degraded send failure again, deadline not yet due: no new retry
    row = '{mk_req(0, 32'd1998, 1, 1, 0, 0, 17'd65536), 1,
            mk_status(LS_DEGR, 0, 0, 16'd1, 16'd2000, 32'd1999, 1)};
    steps = {steps, row};
    // probe at the deadline succeeds
    row = '{mk_req(0, 32'd1999, 0, 1, 0, 0, 17'd65536), 1,
            mk_status(LS_CONN, 1, 0, 16'd0, 16'd0, 32'd0, 0)};
    steps = {steps, row};
    // zero jitter: the final clamp brings the backoff back up to base
    row = '{mk_req(0, 32'd5000, 0, 0, 0, 0, 17'd0), 1,
            mk_status(LS_DISC, 1, 0, 16'd1, 16'd1000, 32'd6000, 1)};
    steps = {steps, row};
    // failures at each deadline: doubling, hitting the cap, then the 8-doubling limit
    begin
      logic [NOW_W-1:0] climb [9];
      climb = '{32'd6000, 32'd8000, 32'd12000, 32'd20000, 32'd36000, 32'd68000,
                32'd128000, 32'd188000, 32'd248000};
      for (i = 0; i < 9; i++) begin
        row = '{mk_req(0, climb[i], 0, 0, 0, 0, 17'd65536), 0, '0};
        steps = {steps, row};
      end
    end
    // at the cap with the jitter window's edges
    row = '{mk_req(0, 32'd308000, 0, 0, 0, 0, 17'd74711), 0, '0};
    steps = {steps, row};
    row = '{mk_req(0, 32'd368000, 0, 0, 0, 0, 17'd57672), 0, '0};
    steps = {steps, row};
    // link comes back with a good send: all retry state cleared
    row = '{mk_req(0, 32'd400000, 1, 0, 1, 1, 17'd65536), 0, '0};
    steps = {steps, row};

    foreach (steps[j]) send_request(steps[j].r, steps[j].typed, steps[j].want);
    in_valid = 1'b0;

    // smallest base (written below range, clamps up)
    write_base(15'd0);
    last_now = 32'd400000;
    run_random(150);

    // largest base (all ones, clamps down); long receiver hold-off with the sender flat out
    write_base(15'h7FFF);
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    run_random(120);
    gaps_on = 1'b1;

    // just below the minimum; no idling on either side, time crossing the 32-bit wrap
    write_base(15'd99);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    last_now  = 32'hFFFF_F000;
    run_random(150);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    // exact range limits
    write_base(BASE_MIN);
    run_random(100);
    write_base(BASE_MAX);
    run_random(100);

    // any register value
    write_base(BASE_W'($urandom_range(0, 32767)));
    run_random(100);

    // drain, then give the pipeline a few more edges to show any stray status
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
